[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BCA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bca_pkg.sv]
// ----------------------------------------------------------------------------
// bca_pkg
// Operation, status and bound-register codes and the per-stage control word.
// ----------------------------------------------------------------------------
package bca_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [2:0] K_ADD = 3'd0;
  localparam logic [2:0] K_SUB = 3'd1;
  localparam logic [2:0] K_MUL = 3'd2;
  localparam logic [2:0] K_DIV = 3'd3;
  localparam logic [2:0] K_REM = 3'd4;
  localparam logic [2:0] K_RNG = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_RSVD = 2'd3;

  localparam logic [1:0] REG_BOUND_LOW  = 2'd0;
  localparam logic [1:0] REG_BOUND_HIGH = 2'd1;

  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
    logic       l_neg;
    logic       l_zero;
    logic       r_neg;
    logic       r_zero;
    logic       r_m1;
  } ctl_t;

endpackage

[hw/rtl/bca_cell.sv]
// ----------------------------------------------------------------------------
// bca_cell
// One stage of the chain: one restoring divide step and one shift-add
// multiply step on magnitudes, registered toward the next cell.
// ----------------------------------------------------------------------------
module bca_cell import bca_pkg::*; #(
  parameter int W = DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  ctl_t           up_ctl,
  input  logic [W-1:0]   up_l,
  input  logic [W-1:0]   up_r,
  input  logic [W-1:0]   up_dvd,
  input  logic [W-1:0]   up_rem,
  input  logic [W-1:0]   up_quo,
  input  logic [W-1:0]   up_mpl,
  input  logic [W-1:0]   up_mcd,
  input  logic [2*W-1:0] up_acc,
  output ctl_t           dn_ctl,
  output logic [W-1:0]   dn_l,
  output logic [W-1:0]   dn_r,
  output logic [W-1:0]   dn_dvd,
  output logic [W-1:0]   dn_rem,
  output logic [W-1:0]   dn_quo,
  output logic [W-1:0]   dn_mpl,
  output logic [W-1:0]   dn_mcd,
  output logic [2*W-1:0] dn_acc
);

  logic [W:0]     trial;
  logic [W:0]     diff;
  logic           take;
  logic [W-1:0]   rem_next;
  logic [W:0]     sum;
  logic [2*W-1:0] acc_next;

  always_comb begin
    trial    = {up_rem, up_dvd[W-1]};
    diff     = trial - {1'b0, up_mcd};
    take     = !diff[W];
    rem_next = take ? diff[W-1:0] : trial[W-1:0];
    sum      = {1'b0, up_acc[2*W-1:W]} + (up_mpl[0] ? {1'b0, up_mcd} : '0);
    acc_next = {sum, up_acc[W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_ctl.valid <= 1'b0;
    end else if (en) begin
      dn_ctl.valid <= up_ctl.valid;
    end
    if (en) begin
      dn_ctl.kind   <= up_ctl.kind;
      dn_ctl.l_neg  <= up_ctl.l_neg;
      dn_ctl.l_zero <= up_ctl.l_zero;
      dn_ctl.r_neg  <= up_ctl.r_neg;
      dn_ctl.r_zero <= up_ctl.r_zero;
      dn_ctl.r_m1   <= up_ctl.r_m1;
      dn_l          <= up_l;
      dn_r          <= up_r;
      dn_dvd        <= {up_dvd[W-2:0], 1'b0};
      dn_rem        <= rem_next;
      dn_quo        <= {up_quo[W-2:0], take};
      dn_mpl        <= {1'b0, up_mpl[W-1:1]};
      dn_mcd        <= up_mcd;
      dn_acc        <= acc_next;
    end
  end

endmodule

[hw/rtl/bca_finish.sv]
// ----------------------------------------------------------------------------
// bca_finish
// Sign correction, bound tests and result selection at the end of the chain.
// ----------------------------------------------------------------------------
module bca_finish import bca_pkg::*; #(
  parameter int W = DATA_WIDTH_DEF
) (
  input  ctl_t           ctl,
  input  logic [W-1:0]   l,
  input  logic [W-1:0]   r,
  input  logic [W-1:0]   quo,
  input  logic [W-1:0]   rem,
  input  logic [2*W-1:0] acc,
  input  logic [W-1:0]   bound_low,
  input  logic [W-1:0]   bound_high,
  output logic [W-1:0]   result_value,
  output logic [1:0]     status
);

  localparam int E = 2 * W + 2;

  logic signed [E-1:0] le, re, loe, hie, pe, se, de, acce;
  logic                r_pos, l_pos, lo_nonneg, hi_nonpos;
  logic                add_ov, sub_ov, mul_ov;
  logic [W-1:0]        q_s, rem_s;

  always_comb begin
    le        = {{(E-W){l[W-1]}}, l};
    re        = {{(E-W){r[W-1]}}, r};
    loe       = {{(E-W){bound_low[W-1]}}, bound_low};
    hie       = {{(E-W){bound_high[W-1]}}, bound_high};
    acce      = {2'b00, acc};
    pe        = (ctl.l_neg ^ ctl.r_neg) ? -acce : acce;
    se        = le + re;
    de        = le - re;
    r_pos     = !ctl.r_neg && !ctl.r_zero;
    l_pos     = !ctl.l_neg && !ctl.l_zero;
    lo_nonneg = !bound_low[W-1];
    hi_nonpos = bound_high[W-1] || (bound_high == '0);
    add_ov    = (r_pos && (se > hie)) || (ctl.r_neg && (se < loe));
    sub_ov    = (ctl.r_neg && (de > hie)) || (r_pos && (de < loe));
    mul_ov    = !ctl.l_zero && !ctl.r_zero && (
                  (l_pos && r_pos && (pe > hie)) ||
                  (l_pos && ctl.r_neg && (lo_nonneg ? (pe + le <= loe) : (pe < loe))) ||
                  (r_pos && (lo_nonneg ? (pe + re <= loe) : (pe < loe))) ||
                  (ctl.r_neg && (hi_nonpos ? (pe + re >= hie) : (pe > hie))));
    q_s       = (ctl.l_neg ^ ctl.r_neg) ? -quo : quo;
    rem_s     = ctl.l_neg ? -rem : rem;

    result_value = l;
    status       = ST_OK;
    case (ctl.kind)
      K_ADD: begin
        if (add_ov) status = ST_OVF;
        else        result_value = se[W-1:0];
      end
      K_SUB: begin
        if (sub_ov) status = ST_OVF;
        else        result_value = de[W-1:0];
      end
      K_MUL: begin
        if (mul_ov) status = ST_OVF;
        else        result_value = pe[W-1:0];
      end
      K_DIV: begin
        if (ctl.r_zero)                     status = ST_DIVZ;
        else if (l == bound_low && ctl.r_m1) status = ST_OVF;
        else                                 result_value = q_s;
      end
      K_REM: begin
        if (ctl.r_zero) status = ST_DIVZ;
        else            result_value = rem_s;
      end
      K_RNG: begin
        status = ((le >= loe) && (le <= hie)) ? ST_OK : ST_OVF;
      end
      default: begin
        status = ST_OVF;
      end
    endcase
  end

endmodule

[hw/rtl/bounded_checked_integer_alu_unit.sv]
// ----------------------------------------------------------------------------
// bounded_checked_integer_alu_unit
// Checked add, subtract, multiply, divide, remainder and range check against
// configurable bounds, as a pipelined chain of multiply/divide cells.
//
//   channel  signals                               direction
//   op       op_valid op_stall kind left/right     in
//   res      res_valid res_stall result_value st   out
//   cfg      cfg_valid cfg_ready cfg_index data    in
//
// The pipeline is an input stage, one cell per operand bit (each does
// one divide step and one multiply step), and the result register.
// One transaction per cycle enters while res is not stalled.
// The whole chain holds while the result register is full and stalled.
// Reset clears valid bits and sets the bounds to the widest range.
// ----------------------------------------------------------------------------
module bounded_checked_integer_alu_unit import bca_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  op_valid,
  output logic                  op_stall,
  input  logic [2:0]            kind,
  input  logic [DATA_WIDTH-1:0] left_operand,
  input  logic [DATA_WIDTH-1:0] right_operand,
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic [DATA_WIDTH-1:0] result_value,
  output logic [1:0]            status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [DATA_WIDTH-1:0] cfg_data
);

  `include "assert_macros.svh"

  localparam int W = DATA_WIDTH;

  logic           adv;
  logic [W-1:0]   bound_low, bound_high;
  ctl_t           ctl_s [0:W];
  logic [W-1:0]   l_s   [0:W];
  logic [W-1:0]   r_s   [0:W];
  logic [W-1:0]   dvd_s [0:W];
  logic [W-1:0]   rem_s [0:W];
  logic [W-1:0]   quo_s [0:W];
  logic [W-1:0]   mpl_s [0:W];
  logic [W-1:0]   mcd_s [0:W];
  logic [2*W-1:0] acc_s [0:W];
  logic [W-1:0]   abs_l, abs_r;
  logic [W-1:0]   fin_value;
  logic [1:0]     fin_status;

  assign adv       = !res_valid || !res_stall;
  assign op_stall  = !adv;
  assign cfg_ready = 1'b1;
  assign abs_l     = left_operand[W-1] ? -left_operand : left_operand;
  assign abs_r     = right_operand[W-1] ? -right_operand : right_operand;

  always_ff @(posedge clk) begin
    if (rst) begin
      bound_low  <= {1'b1, {(W-1){1'b0}}};
      bound_high <= {1'b0, {(W-1){1'b1}}};
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_BOUND_LOW)  bound_low  <= cfg_data;
      if (cfg_index == REG_BOUND_HIGH) bound_high <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s[0].valid <= 1'b0;
    end else if (adv) begin
      ctl_s[0].valid <= op_valid;
    end
    if (adv) begin
      ctl_s[0].kind   <= kind;
      ctl_s[0].l_neg  <= left_operand[W-1];
      ctl_s[0].l_zero <= (left_operand == '0);
      ctl_s[0].r_neg  <= right_operand[W-1];
      ctl_s[0].r_zero <= (right_operand == '0);
      ctl_s[0].r_m1   <= &right_operand;
      l_s[0]          <= left_operand;
      r_s[0]          <= right_operand;
      dvd_s[0]        <= abs_l;
      rem_s[0]        <= '0;
      quo_s[0]        <= '0;
      mpl_s[0]        <= abs_l;
      mcd_s[0]        <= abs_r;
      acc_s[0]        <= '0;
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_cell
    bca_cell #(.W(W)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .up_ctl (ctl_s[i]),
      .up_l   (l_s[i]),
      .up_r   (r_s[i]),
      .up_dvd (dvd_s[i]),
      .up_rem (rem_s[i]),
      .up_quo (quo_s[i]),
      .up_mpl (mpl_s[i]),
      .up_mcd (mcd_s[i]),
      .up_acc (acc_s[i]),
      .dn_ctl (ctl_s[i+1]),
      .dn_l   (l_s[i+1]),
      .dn_r   (r_s[i+1]),
      .dn_dvd (dvd_s[i+1]),
      .dn_rem (rem_s[i+1]),
      .dn_quo (quo_s[i+1]),
      .dn_mpl (mpl_s[i+1]),
      .dn_mcd (mcd_s[i+1]),
      .dn_acc (acc_s[i+1])
    );
  end

  bca_finish #(.W(W)) u_finish (
    .ctl          (ctl_s[W]),
    .l            (l_s[W]),
    .r            (r_s[W]),
    .quo          (quo_s[W]),
    .rem          (rem_s[W]),
    .acc          (acc_s[W]),
    .bound_low    (bound_low),
    .bound_high   (bound_high),
    .result_value (fin_value),
    .status       (fin_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= ctl_s[W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_value <= fin_value;
      status       <= fin_status;
    end
  end

  `BCA_ASSERT_IMPL(a_stall_follows_out, 1'b1, op_stall == (res_valid && res_stall),
    "op_stall does not follow the result register")
  `BCA_ASSERT_IMPL(a_no_rsvd_status, res_valid, status != ST_RSVD,
    "reserved status code on result")
  `BCA_ASSERT_NEXT(a_divz_reported,
    adv && ctl_s[W].valid && ctl_s[W].r_zero && (ctl_s[W].kind == K_DIV || ctl_s[W].kind == K_REM),
    res_valid && status == ST_DIVZ, "zero divisor not reported")

endmodule

[test/bounded_checked_integer_alu_unit_test.sv]
// ----------------------------------------------------------------------------
// bounded_checked_integer_alu_unit_test
// Self-checking bench for the checked integer ALU. Operations are driven
// with random gaps, results are taken with random stalls, and each result
// is compared against a bound-aware prediction of value and status. Bound
// registers are rewritten between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module bounded_checked_integer_alu_unit_test import bca_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 32;
  localparam int PIPE_DEPTH = W + 2;
  localparam logic signed [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};

  typedef struct packed {
    logic [W-1:0] value;
    logic [1:0]   st;
  } alu_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         op_valid = 1'b0;
  logic         op_stall;
  logic [2:0]   kind = K_ADD;
  logic [W-1:0] left_operand = '0;
  logic [W-1:0] right_operand = '0;
  logic         res_valid;
  logic         res_stall = 1'b0;
  logic [W-1:0] result_value;
  logic [1:0]   status;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = REG_BOUND_LOW;
  logic [W-1:0] cfg_data = '0;

  logic signed [W-1:0] bound_lo = MIN_VAL;
  logic signed [W-1:0] bound_hi = MAX_VAL;
  alu_result_t         pending_results[$];
  int                  error_count = 0;
  bit                  quiet = 1'b0;
  logic                res_hold = 1'b0;

  bounded_checked_integer_alu_unit #(.DATA_WIDTH(W)) uut (
    .clk(clk), .rst(rst),
    .op_valid(op_valid), .op_stall(op_stall), .kind(kind),
    .left_operand(left_operand), .right_operand(right_operand),
    .res_valid(res_valid), .res_stall(res_stall),
    .result_value(result_value), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("[bounded_checked_integer_alu_unit] ERROR");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic alu_result_t predict_alu(input logic [2:0] k,
                                              input logic signed [W-1:0] lw,
                                              input logic signed [W-1:0] rw);
    longint l, r, lo, hi;
    alu_result_t o;
    bit ovf;
    l = lw;
    r = rw;
    lo = bound_lo;
    hi = bound_hi;
    o.value = lw;
    o.st = ST_OK;
    ovf = 1'b0;
    case (k)
      K_ADD: begin
        if ((r > 0 && l + r > hi) || (r < 0 && l + r < lo)) o.st = ST_OVF;
        else o.value = lw + rw;
      end
      K_SUB: begin
        if ((r < 0 && l - r > hi) || (r > 0 && l - r < lo)) o.st = ST_OVF;
        else o.value = lw - rw;
      end
      K_MUL: begin
        if (l != 0 && r != 0) begin
          if (l > 0 && ((r > 0 && l > hi / r) || (r < 0 && r < lo / l))) ovf = 1'b1;
          else if ((r > 0 && l < lo / r) || (r < 0 && l < hi / r)) ovf = 1'b1;
        end
        if (ovf) o.st = ST_OVF;
        else o.value = lw * rw;
      end
      K_DIV: begin
        if (r == 0) o.st = ST_DIVZ;
        else if (l == lo && r == -1) o.st = ST_OVF;
        else o.value = l / r;
      end
      K_REM: begin
        if (r == 0) o.st = ST_DIVZ;
        else if (r == -1) o.value = '0;
        else o.value = l % r;
      end
      K_RNG: o.st = (l >= lo && l <= hi) ? ST_OK : ST_OVF;
      default: o.st = ST_OVF;
    endcase
    return o;
  endfunction

  // result side: check and stall
  always @(posedge clk) begin
    int stall_left;
    alu_result_t want;
    if (rst) begin
      stall_left = 0;
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (pending_results.size() == 0) begin
          report("result with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (result_value !== want.value)
            report($sformatf("value %h, want %h", result_value, want.value));
          if (status !== want.st)
            report($sformatf("status %0d, want %0d", status, want.st));
        end
        stall_left = quiet ? 0 : $urandom_range(0, 13);
      end
      if (res_hold) begin
        res_stall <= 1'b1;
      end else if (stall_left > 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  task automatic send_op(input logic [2:0] k, input logic [W-1:0] l,
                         input logic [W-1:0] r);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      op_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op_valid <= 1'b1;
    kind <= k;
    left_operand <= l;
    right_operand <= r;
    do @(posedge clk); while (op_stall);
    pending_results.push_back(predict_alu(k, l, r));
  endtask

  task automatic drain;
    int guard;
    op_valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 100_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (PIPE_DEPTH + 8) @(posedge clk);
  endtask

  task automatic write_bound(input logic [1:0] idx, input logic [W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_BOUND_LOW) bound_lo = data;
    else bound_hi = data;
  endtask

  task automatic set_bounds(input logic [W-1:0] lo, input logic [W-1:0] hi);
    drain();
    write_bound(REG_BOUND_LOW, lo);
    write_bound(REG_BOUND_HIGH, hi);
    @(posedge clk);
  endtask

  function automatic logic [W-1:0] pick_operand();
    int sel;
    sel = $urandom_range(0, 15);
    case (sel)
      0: return '0;
      1: return 1;
      2: return '1;
      3: return MIN_VAL;
      4: return MAX_VAL;
      5: return bound_lo + $signed($urandom_range(0, 4)) - 2;
      6: return bound_hi + $signed($urandom_range(0, 4)) - 2;
      7, 8: return $signed($urandom_range(0, 200)) - 100;
      9: return $signed($urandom_range(0, 131071)) - 65536;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_ops(input int count);
    logic [2:0] k;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      k = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                       : 3'($urandom_range(0, 5));
      if (k == K_DIV && $urandom_range(0, 9) == 0)
        send_op(k, bound_lo, '1);
      else
        send_op(k, pick_operand(), pick_operand());
    end
    quiet = 1'b0;
  endtask

  task automatic test_directed;
    send_op(K_ADD, MAX_VAL, 1);
    send_op(K_ADD, MIN_VAL, '1);
    send_op(K_ADD, MAX_VAL, MIN_VAL);
    send_op(K_SUB, MIN_VAL, 1);
    send_op(K_SUB, MAX_VAL, '1);
    send_op(K_SUB, 5, 0);
    send_op(K_MUL, MAX_VAL, 2);
    send_op(K_MUL, MIN_VAL, '1);
    send_op(K_MUL, 0, MIN_VAL);
    send_op(K_MUL, 46341, 46341);
    send_op(K_MUL, -46341, 46340);
    send_op(K_DIV, 7, 0);
    send_op(K_DIV, MIN_VAL, '1);
    send_op(K_DIV, -7, 2);
    send_op(K_REM, 7, 0);
    send_op(K_REM, MIN_VAL, '1);
    send_op(K_REM, -7, 2);
    send_op(K_RNG, MIN_VAL, MAX_VAL);
    send_op(K_RNG, MAX_VAL, 0);
    send_op(3'd6, 12, 3);
    send_op(3'd7, '1, '1);
    set_bounds(-100, 100);
    send_op(K_RNG, 101, 0);
    send_op(K_DIV, MIN_VAL, '1);
    send_op(K_DIV, -100, '1);
    send_op(K_ADD, 500, 1);
    drain();
  endtask

  task automatic test_bounds;
    set_bounds(MIN_VAL, MIN_VAL + 1);
    random_ops(50);
    set_bounds(MAX_VAL - 1, MAX_VAL);
    random_ops(50);
    set_bounds(-1, 0);
    random_ops(50);
    set_bounds(1000, -1000);
    random_ops(40);
    set_bounds($urandom_range(0, 65535) - 70000, $urandom_range(0, 65535));
    random_ops(60);
    drain();
  endtask

  task automatic test_pressure;
    set_bounds(MIN_VAL, MAX_VAL);
    quiet = 1'b1;
    fork
      begin
        res_hold <= 1'b1;
        repeat (300) @(posedge clk);
        res_hold <= 1'b0;
      end
    join_none
    random_ops(80);
    drain();
  endtask

  task automatic test_random;
    set_bounds(-(1 << 20), 1 << 20);
    random_ops(200);
    set_bounds(MIN_VAL, MAX_VAL);
    random_ops(200);
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_bounds();
    test_pressure();
    test_random();
    if (error_count == 0) begin
      $display("[bounded_checked_integer_alu_unit] OK");
    end else begin
      $display("[bounded_checked_integer_alu_unit] ERROR");
    end
    $finish;
  end
endmodule
